### rtl/pf_pkg.sv
`default_nettype none

package pf_pkg;

  localparam int unsigned SqDim     = 5;
  localparam int unsigned CharW     = 8;
  localparam int unsigned RowW      = SqDim * CharW;
  localparam int unsigned PosW      = $clog2(SqDim);
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = RowW;

  typedef logic [CharW-1:0]                    char_t;
  typedef logic [PosW-1:0]                     pos_t;
  typedef logic [SqDim-1:0][SqDim-1:0][CharW-1:0] key_sq_t;   // [row][col]
  typedef logic [SqDim-1:0][SqDim-1:0]         hit_map_t;     // [row][col]

  typedef enum logic {
    FuncEnc = 1'b0,
    FuncDec = 1'b1
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyRow0 = 3'd0,
    CfgKeyRow1 = 3'd1,
    CfgKeyRow2 = 3'd2,
    CfgKeyRow3 = 3'd3,
    CfgKeyRow4 = 3'd4
  } cfg_reg_e;

  // Rows MONAR / CHYBD / EFGIK / LPQST / UVWXZ, row 0 in the low slot
  localparam logic [SqDim-1:0][RowW-1:0] KeyRowReset = {
    40'd388029175381,
    40'd362175090764,
    40'd323351955013,
    40'd293170923587,
    40'd353282969421
  };

  // Compare stage result
  typedef struct packed {
    func_e    func;
    hit_map_t hit_a;
    hit_map_t hit_b;
  } match_t;

  // Locate stage result
  typedef struct packed {
    func_e func;
    logic  found_a;
    pos_t  row_a;
    pos_t  col_a;
    logic  found_b;
    pos_t  row_b;
    pos_t  col_b;
  } loc_t;

  // Rule stage result: coordinates to read out
  typedef struct packed {
    logic not_found;
    pos_t row_a;
    pos_t col_a;
    pos_t row_b;
    pos_t col_b;
  } tgt_t;

  // Wrapping step of one position, forwards or backwards
  function automatic pos_t step_pos(pos_t p, func_e f);
    pos_t r;
    if (f == FuncDec) begin
      r = (p == '0) ? pos_t'(SqDim - 1) : pos_t'(p - pos_t'(1));
    end else begin
      r = (p == pos_t'(SqDim - 1)) ? '0 : pos_t'(p + pos_t'(1));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/pf_in_if.sv
`default_nettype none

interface pf_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] first_letter;
  logic [7:0] second_letter;

  modport source (output valid, func, first_letter, second_letter, input ready);
  modport sink   (input valid, func, first_letter, second_letter, output ready);
endinterface

`default_nettype wire

### rtl/pf_out_if.sv
`default_nettype none

interface pf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_first;
  logic [7:0] out_second;
  logic       not_found;

  modport source (output valid, out_first, out_second, not_found, input ready);
  modport sink   (input valid, out_first, out_second, not_found, output ready);
endinterface

`default_nettype wire

### rtl/pf_match.sv
`default_nettype none

module pf_match import pf_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire key_sq_t key_i,
  input  wire logic    valid_i,
  input  wire logic    func_i,
  input  wire char_t   first_i,
  input  wire char_t   second_i,
  output      logic    ready_o,
  output      logic    valid_o,
  output      match_t  data_o,
  input  wire logic    ready_i
);

  logic   valid_q;
  match_t data_d, data_q;

  always_comb begin
    data_d.func = func_e'(func_i);
    for (int r = 0; r < SqDim; r++) begin
      for (int c = 0; c < SqDim; c++) begin
        data_d.hit_a[r][c] = (key_i[r][c] == first_i);
        data_d.hit_b[r][c] = (key_i[r][c] == second_i);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### rtl/pf_locate.sv
`default_nettype none

module pf_locate import pf_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   valid_i,
  input  wire match_t data_i,
  output      logic   ready_o,
  output      logic   valid_o,
  output      loc_t   data_o,
  input  wire logic   ready_i
);

  logic valid_q;
  loc_t data_d, data_q;

  // First hit in row-major order wins: scan backwards so the lowest survives
  always_comb begin
    data_d.func    = data_i.func;
    data_d.found_a = |data_i.hit_a;
    data_d.found_b = |data_i.hit_b;
    data_d.row_a   = '0;
    data_d.col_a   = '0;
    data_d.row_b   = '0;
    data_d.col_b   = '0;
    for (int r = SqDim - 1; r >= 0; r--) begin
      for (int c = SqDim - 1; c >= 0; c--) begin
        if (data_i.hit_a[r][c]) begin
          data_d.row_a = pos_t'(r);
          data_d.col_a = pos_t'(c);
        end
        if (data_i.hit_b[r][c]) begin
          data_d.row_b = pos_t'(r);
          data_d.col_b = pos_t'(c);
        end
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### rtl/pf_rule.sv
`default_nettype none

module pf_rule import pf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  input  wire loc_t data_i,
  output      logic ready_o,
  output      logic valid_o,
  output      tgt_t data_o,
  input  wire logic ready_i
);

  logic valid_q;
  tgt_t data_d, data_q;

  always_comb begin
    data_d.not_found = !(data_i.found_a && data_i.found_b);
    priority if (data_i.row_a == data_i.row_b) begin
      // same row, equal letters included: step along the row
      data_d.row_a = data_i.row_a;
      data_d.row_b = data_i.row_b;
      data_d.col_a = step_pos(data_i.col_a, data_i.func);
      data_d.col_b = step_pos(data_i.col_b, data_i.func);
    end else if (data_i.col_a == data_i.col_b) begin
      data_d.row_a = step_pos(data_i.row_a, data_i.func);
      data_d.row_b = step_pos(data_i.row_b, data_i.func);
      data_d.col_a = data_i.col_a;
      data_d.col_b = data_i.col_b;
    end else begin
      // rectangle: swap the columns
      data_d.row_a = data_i.row_a;
      data_d.row_b = data_i.row_b;
      data_d.col_a = data_i.col_b;
      data_d.col_b = data_i.col_a;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### rtl/pf_select.sv
`default_nettype none

module pf_select import pf_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire key_sq_t key_i,
  input  wire logic    valid_i,
  input  wire tgt_t    data_i,
  output      logic    ready_o,
  output      logic    valid_o,
  output      char_t   out_first_o,
  output      char_t   out_second_o,
  output      logic    not_found_o,
  input  wire logic    ready_i
);

  logic  valid_q;
  char_t first_d, first_q;
  char_t second_d, second_q;
  logic  not_found_q;

  always_comb begin
    if (data_i.not_found) begin
      first_d  = '0;
      second_d = '0;
    end else begin
      first_d  = key_i[data_i.row_a][data_i.col_a];
      second_d = key_i[data_i.row_b][data_i.col_b];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      first_q     <= first_d;
      second_q    <= second_d;
      not_found_q <= data_i.not_found;
    end
  end

  assign valid_o      = valid_q;
  assign out_first_o  = first_q;
  assign out_second_o = second_q;
  assign not_found_o  = not_found_q;

endmodule

`default_nettype wire

### rtl/playfair_digraph_cipher_core.sv
// A letter pair passes through the compare, locate, rule and read-out stages in order.
// Throughput: one pair per cycle while the output channel is ready; each of these
// stages holds one transaction, and each stage advances when the one after it is free.
// Reset: all stage valid bits clear and the key square returns to
// MONAR / CHYBD / EFGIK / LPQST / UVWXZ.
`default_nettype none

module playfair_digraph_cipher_core import pf_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  pf_in_if.sink                    in_if,
  pf_out_if.source                 out_if,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic [SqDim-1:0][RowW-1:0] key_q;
  key_sq_t                    key_sq;

  logic   m_valid, m_ready;
  match_t m_data;
  logic   l_valid, l_ready;
  loc_t   l_data;
  logic   r_valid, r_ready;
  tgt_t   r_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KeyRowReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgKeyRow0: key_q[0] <= cfg_data_i;
        CfgKeyRow1: key_q[1] <= cfg_data_i;
        CfgKeyRow2: key_q[2] <= cfg_data_i;
        CfgKeyRow3: key_q[3] <= cfg_data_i;
        CfgKeyRow4: key_q[4] <= cfg_data_i;
        default: ;  // drop writes beyond the last row
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < SqDim; r++) begin
      for (int c = 0; c < SqDim; c++) begin
        key_sq[r][c] = key_q[r][c*CharW +: CharW];
      end
    end
  end

  pf_match u_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_i    (key_sq),
    .valid_i  (in_if.valid),
    .func_i   (in_if.func),
    .first_i  (in_if.first_letter),
    .second_i (in_if.second_letter),
    .ready_o  (in_if.ready),
    .valid_o  (m_valid),
    .data_o   (m_data),
    .ready_i  (m_ready)
  );

  pf_locate u_locate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_valid),
    .data_i  (m_data),
    .ready_o (m_ready),
    .valid_o (l_valid),
    .data_o  (l_data),
    .ready_i (l_ready)
  );

  pf_rule u_rule (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (l_valid),
    .data_i  (l_data),
    .ready_o (l_ready),
    .valid_o (r_valid),
    .data_o  (r_data),
    .ready_i (r_ready)
  );

  pf_select u_select (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key_sq),
    .valid_i      (r_valid),
    .data_i       (r_data),
    .ready_o      (r_ready),
    .valid_o      (out_if.valid),
    .out_first_o  (out_if.out_first),
    .out_second_o (out_if.out_second),
    .not_found_o  (out_if.not_found),
    .ready_i      (out_if.ready)
  );

endmodule

`default_nettype wire
